FILE: hdl/tlcf_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tlcf_pkg: shared types and constants of the two-link contact force block
// Holds the fixed-point angle constants, the CORDIC arctangent table, the
// payload structs that travel down the cell chains and the register codes.
// ----------------------------------------------------------------------------
package tlcf_pkg;

   // Angle constants in Q16 radians.
   localparam logic signed [20:0] PI_Q16      = 21'sd205887;
   localparam logic signed [20:0] NEG_PI_Q16  = -21'sd205887;
   localparam logic signed [20:0] TWO_PI_Q16  = 21'sd411774;
   localparam logic signed [20:0] HALF_PI_Q16 = 21'sd102944;
   localparam logic signed [20:0] NEG_HALF_PI_Q16 = -21'sd102944;

   // CORDIC start vector, gain compensated, Q30.
   localparam logic signed [32:0] CORDIC_GAIN_Q30 = 33'sd652032874;
   localparam int CORDIC_STEPS = 16;
   localparam int DIV_STEPS    = 32;

   // Force magnitude limits.
   localparam logic [31:0] MAG_POS_MAX = 32'h7FFF_FFFF;
   localparam logic [31:0] MAG_NEG_MAX = 32'h8000_0000;

   // Configuration register indexes.
   typedef enum logic [2:0] {
      CSR_PROXIMAL_LENGTH = 3'd0,
      CSR_DISTAL_LENGTH   = 3'd1,
      CSR_SURFACE_EXTENT  = 3'd2,
      CSR_STIFFNESS       = 3'd3,
      CSR_FRICTION_COEFF  = 3'd4,
      CSR_SURFACE_MODE    = 3'd5
   } csr_index_type;

   localparam logic [7:0] SURFACE_FLAT = 8'd1;

   // One CORDIC lane: vector, residual angle and the half-turn flip flag.
   typedef struct packed {
      logic signed [32:0] x;
      logic signed [32:0] y;
      logic signed [20:0] z;
      logic               flip;
   } lane_type;

   typedef struct packed {
      logic [31:0] sec;
      logic [29:0] nsec;
   } stamp_type;

   typedef struct packed {
      stamp_type          stamp;
      logic signed [23:0] bx;
      logic signed [23:0] by;
   } cordic_side_type;

   // Control flags that ride along the divider chain.
   typedef struct packed {
      logic contact;
      logic neg;
      logic pzero;
      logic czero;
      logic ovf;
   } div_ctl_type;

   // Restoring divider working set.
   typedef struct packed {
      logic [31:0] rem;
      logic [31:0] dvs;
      logic [31:0] num;
      logic [31:0] quo;
   } div_type;

   // Arctangent of 2^-idx in Q16.
   function automatic logic signed [20:0] atan_q16(input int idx);
      logic signed [20:0] v;
      case (idx)
         0:  v = 21'sd51472;
         1:  v = 21'sd30386;
         2:  v = 21'sd16055;
         3:  v = 21'sd8150;
         4:  v = 21'sd4091;
         5:  v = 21'sd2047;
         6:  v = 21'sd1024;
         7:  v = 21'sd512;
         8:  v = 21'sd256;
         9:  v = 21'sd128;
         10: v = 21'sd64;
         11: v = 21'sd32;
         12: v = 21'sd16;
         13: v = 21'sd8;
         14: v = 21'sd4;
         15: v = 21'sd2;
         default: v = 21'sd0;
      endcase
      return v;
   endfunction

   // Scale a Q3.13 angle sum to Q16, wrap it into one turn and fold it into
   // the right half plane; the flip flag negates the results later.
   function automatic lane_type prep_angle(input logic signed [16:0] sum);
      logic signed [20:0] a;
      logic signed [20:0] z;
      lane_type l;
      a = {sum[16], sum, 3'b000};
      if (a > PI_Q16) begin
         z = a - TWO_PI_Q16;
      end else if (a < NEG_PI_Q16) begin
         z = a + TWO_PI_Q16;
      end else begin
         z = a;
      end
      l.flip = 1'b0;
      if (z > HALF_PI_Q16) begin
         z = z - PI_Q16;
         l.flip = 1'b1;
      end else if (z < NEG_HALF_PI_Q16) begin
         z = z + PI_Q16;
         l.flip = 1'b1;
      end
      l.x = CORDIC_GAIN_Q30;
      l.y = 33'sd0;
      l.z = z;
      return l;
   endfunction

endpackage
`default_nettype wire

FILE: hdl/tlcf_cordic_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tlcf_cordic_cell: one rotation step of the two-lane CORDIC chain
// Rotates both angle lanes by the arctangent of 2^-IDX and registers them,
// together with the transaction's side data, for the next cell.
// ----------------------------------------------------------------------------
module tlcf_cordic_cell #(
   parameter int IDX = 0
) (
   input  wire                        clock,
   input  wire                        reset,
   input  wire                        in_valid,
   input  tlcf_pkg::lane_type         in_a,
   input  tlcf_pkg::lane_type         in_b,
   input  tlcf_pkg::cordic_side_type  in_side,
   input  wire                        room_in,
   output logic                       room_out,
   output logic                       out_valid,
   output tlcf_pkg::lane_type         out_a,
   output tlcf_pkg::lane_type         out_b,
   output tlcf_pkg::cordic_side_type  out_side
);

   localparam logic signed [20:0] ATAN = tlcf_pkg::atan_q16(IDX);

   logic                       valid_ff;
   tlcf_pkg::lane_type         a_ff, a_in;
   tlcf_pkg::lane_type         b_ff, b_in;
   tlcf_pkg::cordic_side_type  side_ff;

   function automatic tlcf_pkg::lane_type rotate(input tlcf_pkg::lane_type l);
      logic signed [32:0] dx;
      logic signed [32:0] dy;
      tlcf_pkg::lane_type r;
      dx = l.y >>> IDX;
      dy = l.x >>> IDX;
      r  = l;
      if (!l.z[20]) begin
         r.x = l.x - dx;
         r.y = l.y + dy;
         r.z = l.z - ATAN;
      end else begin
         r.x = l.x + dx;
         r.y = l.y - dy;
         r.z = l.z + ATAN;
      end
      return r;
   endfunction

   // Rotation of both lanes.
   always_comb begin
      a_in = rotate(in_a);
      b_in = rotate(in_b);
   end

   // The stage takes new data when it is empty or its content moves on.
   assign room_out = !valid_ff || room_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (room_out) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (room_out) begin
         a_ff    <= a_in;
         b_ff    <= b_in;
         side_ff <= in_side;
      end
   end

   assign out_valid = valid_ff;
   assign out_a     = a_ff;
   assign out_b     = b_ff;
   assign out_side  = side_ff;

endmodule
`default_nettype wire

FILE: hdl/tlcf_div_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tlcf_div_cell: one quotient bit of the restoring divider chain
// Shifts in one dividend bit, subtracts the divisor when it fits and passes
// the partial remainder and quotient on to the next cell.
// ----------------------------------------------------------------------------
module tlcf_div_cell (
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     in_valid,
   input  tlcf_pkg::div_type       in_div,
   input  tlcf_pkg::div_ctl_type   in_ctl,
   input  tlcf_pkg::stamp_type     in_stamp,
   input  wire                     room_in,
   output logic                    room_out,
   output logic                    out_valid,
   output tlcf_pkg::div_type       out_div,
   output tlcf_pkg::div_ctl_type   out_ctl,
   output tlcf_pkg::stamp_type     out_stamp
);

   logic                   valid_ff;
   tlcf_pkg::div_type      div_ff, div_in;
   tlcf_pkg::div_ctl_type  ctl_ff;
   tlcf_pkg::stamp_type    stamp_ff;
   logic [33:0]            rem2;
   logic [33:0]            diff;

   // Trial subtraction; the partial remainder stays below a nonzero divisor.
   always_comb begin
      rem2   = {1'b0, in_div.rem, in_div.num[31]};
      diff   = rem2 - {2'b00, in_div.dvs};
      div_in = in_div;
      div_in.num = {in_div.num[30:0], 1'b0};
      if (!diff[33]) begin
         div_in.rem = diff[31:0];
         div_in.quo = {in_div.quo[30:0], 1'b1};
      end else begin
         div_in.rem = rem2[31:0];
         div_in.quo = {in_div.quo[30:0], 1'b0};
      end
   end

   assign room_out = !valid_ff || room_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (room_out) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (room_out) begin
         div_ff   <= div_in;
         ctl_ff   <= in_ctl;
         stamp_ff <= in_stamp;
      end
   end

   assign out_valid = valid_ff;
   assign out_div   = div_ff;
   assign out_ctl   = ctl_ff;
   assign out_stamp = stamp_ff;

endmodule
`default_nettype wire

FILE: hdl/two_link_contact_force.sv
`default_nettype none
// ----------------------------------------------------------------------------
// two_link_contact_force: fingertip contact force of a two-link finger
// Forward kinematics by CORDIC, spring penetration model and friction.
// ----------------------------------------------------------------------------
// Usage:
//  The req_ channel carries a timestamp, two joint angles and the finger base
//  position; each accepted transaction yields exactly one rsp_ transaction
//  with the timestamp, the tangential and normal force and two flags.
//  The csr_ port writes the link lengths, surface and material registers;
//  write it only while no transaction is in flight.
//  From acceptance to rsp_valid a transaction passes one angle preparation
//  stage, 16 CORDIC cells, four kinematics and multiply stages, 32 divider
//  cells, two force stages and the output register.
//  Throughput is one transaction per cycle while the receiver does not stall;
//  every stage is a register that hands its content on when the next has room.
//  When the receiver stalls, the result holds in the output register and
//  the chain keeps filling its empty stages; req_stall rises only when no
//  stage up to the first can move.
//  Reset empties the chain and returns the registers to their reset values
//  (surface_mode flat, all others zero).
// ----------------------------------------------------------------------------
module two_link_contact_force (
   input  wire                clock,
   input  wire                reset,
   // Request channel.
   input  wire                req_valid,
   output logic               req_stall,
   input  wire         [31:0] req_stamp_sec,
   input  wire         [29:0] req_stamp_nsec,
   input  wire  signed [15:0] req_joint_angle,
   input  wire  signed [15:0] req_base_angle,
   input  wire  signed [23:0] req_base_x,
   input  wire  signed [23:0] req_base_y,
   // Response channel.
   output logic               rsp_valid,
   input  wire                rsp_stall,
   output logic        [31:0] rsp_out_stamp_sec,
   output logic        [29:0] rsp_out_stamp_nsec,
   output logic signed [31:0] rsp_force_x,
   output logic signed [31:0] rsp_force_y,
   output logic               rsp_in_contact,
   output logic               rsp_saturated,
   // Register write port.
   input  wire                csr_we,
   input  wire          [2:0] csr_index,
   input  wire         [23:0] csr_wdata
);

   localparam int CS = tlcf_pkg::CORDIC_STEPS;
   localparam int DS = tlcf_pkg::DIV_STEPS;

   // -------------------------------------------------------------------------
   // Configuration registers.
   // -------------------------------------------------------------------------
   logic        [22:0] prox_len_ff;
   logic        [22:0] dist_len_ff;
   logic signed [23:0] extent_ff;
   logic        [23:0] stiff_ff;
   logic        [15:0] mu_ff;
   logic         [7:0] mode_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         prox_len_ff <= '0;
         dist_len_ff <= '0;
         extent_ff   <= '0;
         stiff_ff    <= '0;
         mu_ff       <= '0;
         mode_ff     <= tlcf_pkg::SURFACE_FLAT;
      end else if (csr_we) begin
         unique case (tlcf_pkg::csr_index_type'(csr_index))
            tlcf_pkg::CSR_PROXIMAL_LENGTH: prox_len_ff <= csr_wdata[22:0];
            tlcf_pkg::CSR_DISTAL_LENGTH:   dist_len_ff <= csr_wdata[22:0];
            tlcf_pkg::CSR_SURFACE_EXTENT:  extent_ff   <= $signed(csr_wdata);
            tlcf_pkg::CSR_STIFFNESS:       stiff_ff    <= csr_wdata;
            tlcf_pkg::CSR_FRICTION_COEFF:  mu_ff       <= csr_wdata[15:0];
            tlcf_pkg::CSR_SURFACE_MODE:    mode_ff     <= csr_wdata[7:0];
            default: ;
         endcase
      end
   end

   // -------------------------------------------------------------------------
   // Chain signals. Index 0 of the CORDIC arrays is the preparation stage.
   // -------------------------------------------------------------------------
   logic                       cv  [0:CS];
   tlcf_pkg::lane_type         ca  [0:CS];
   tlcf_pkg::lane_type         cb  [0:CS];
   tlcf_pkg::cordic_side_type  cs  [0:CS];
   logic                       crm [0:CS+1];

   logic                       dv  [0:DS];
   tlcf_pkg::div_type          dd  [0:DS];
   tlcf_pkg::div_ctl_type      dc  [0:DS];
   tlcf_pkg::stamp_type        dst [0:DS];
   logic                       drm [0:1];

   logic room_s1, room_s2, room_s3, room_s5, room_s6, room_out;

   // -------------------------------------------------------------------------
   // Preparation stage: angle sums, wrap and fold.
   // -------------------------------------------------------------------------
   logic                       v0_ff;
   tlcf_pkg::lane_type         a0_ff, b0_ff;
   tlcf_pkg::cordic_side_type  side0_ff;
   logic signed [16:0]         sum_a, sum_b;

   assign sum_a    = 17'(req_base_angle) + 17'(req_joint_angle);
   assign sum_b    = 17'(req_base_angle);
   assign crm[0]   = !v0_ff || crm[1];
   assign req_stall = !crm[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
      end else if (crm[0]) begin
         v0_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (crm[0]) begin
         a0_ff          <= tlcf_pkg::prep_angle(sum_a);
         b0_ff          <= tlcf_pkg::prep_angle(sum_b);
         side0_ff.stamp <= '{sec: req_stamp_sec, nsec: req_stamp_nsec};
         side0_ff.bx    <= req_base_x;
         side0_ff.by    <= req_base_y;
      end
   end

   assign cv[0] = v0_ff;
   assign ca[0] = a0_ff;
   assign cb[0] = b0_ff;
   assign cs[0] = side0_ff;

   // -------------------------------------------------------------------------
   // CORDIC chain, one rotation per cell.
   // -------------------------------------------------------------------------
   for (genvar k = 0; k < CS; k++) begin : g_cordic
      tlcf_cordic_cell #(.IDX(k)) u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (cv[k]),
         .in_a      (ca[k]),
         .in_b      (cb[k]),
         .in_side   (cs[k]),
         .room_in   (crm[k+2]),
         .room_out  (crm[k+1]),
         .out_valid (cv[k+1]),
         .out_a     (ca[k+1]),
         .out_b     (cb[k+1]),
         .out_side  (cs[k+1])
      );
   end
   assign crm[CS+1] = room_s1;

   // -------------------------------------------------------------------------
   // Stage 1: link length products and the signed proximal cosine.
   // -------------------------------------------------------------------------
   logic                v1_ff;
   logic signed [56:0]  ps1_ff, ps2_ff, pc1_ff, pc2_ff;
   logic                flip1_ff, flip2_ff;
   logic signed [32:0]  c1_ff;
   tlcf_pkg::cordic_side_type side1_ff;

   assign room_s1 = !v1_ff || room_s2;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (room_s1) begin
         v1_ff <= cv[CS];
      end
   end

   always_ff @(posedge clock) begin
      if (room_s1) begin
         ps1_ff   <= $signed({1'b0, prox_len_ff}) * ca[CS].y;
         ps2_ff   <= $signed({1'b0, dist_len_ff}) * cb[CS].y;
         pc1_ff   <= $signed({1'b0, prox_len_ff}) * ca[CS].x;
         pc2_ff   <= $signed({1'b0, dist_len_ff}) * cb[CS].x;
         flip1_ff <= ca[CS].flip;
         flip2_ff <= cb[CS].flip;
         c1_ff    <= ca[CS].flip ? -ca[CS].x : ca[CS].x;
         side1_ff <= cs[CS];
      end
   end

   // -------------------------------------------------------------------------
   // Stage 2: tip position, contact test and penetration.
   // -------------------------------------------------------------------------
   logic signed [56:0] ts1, ts2, tc1, tc2;
   logic signed [59:0] hx, hy, hy_neg, ext60;
   logic signed [32:0] cmag33;
   logic               contact_in;

   always_comb begin
      ts1    = flip1_ff ? -ps1_ff : ps1_ff;
      ts2    = flip2_ff ? -ps2_ff : ps2_ff;
      tc1    = flip1_ff ? -pc1_ff : pc1_ff;
      tc2    = flip2_ff ? -pc2_ff : pc2_ff;
      hx     = $signed({{6{side1_ff.bx[23]}}, side1_ff.bx, 30'b0})
               + 60'(ts1) + 60'(ts2);
      hy     = $signed({{6{side1_ff.by[23]}}, side1_ff.by, 30'b0})
               - (60'(tc1) + 60'(tc2));
      hy_neg = -hy;
      ext60  = $signed({{6{extent_ff[23]}}, extent_ff, 30'b0});
      contact_in = (hx <= ext60) && (mode_ff == tlcf_pkg::SURFACE_FLAT)
                   && (hy <= 60'sd0);
      cmag33 = c1_ff[32] ? -c1_ff : c1_ff;
   end

   logic                v2_ff;
   logic        [37:0]  pen_ff;
   logic        [31:0]  cmag2_ff;
   logic                neg2_ff, contact2_ff;
   tlcf_pkg::stamp_type stamp2_ff;

   assign room_s2 = !v2_ff || room_s3;

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (room_s2) begin
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (room_s2) begin
         pen_ff      <= hy_neg[55:18];
         cmag2_ff    <= cmag33[31:0];
         neg2_ff     <= c1_ff[32];
         contact2_ff <= contact_in;
         stamp2_ff   <= side1_ff.stamp;
      end
   end

   // -------------------------------------------------------------------------
   // Stage 3: penetration times stiffness, split into two partial products.
   // -------------------------------------------------------------------------
   logic                v3_ff;
   logic        [42:0]  pp_lo_ff, pp_hi_ff;
   logic        [31:0]  cmag3_ff;
   logic                neg3_ff, contact3_ff;
   tlcf_pkg::stamp_type stamp3_ff;

   assign room_s3 = !v3_ff || drm[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else if (room_s3) begin
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (room_s3) begin
         pp_lo_ff    <= pen_ff[18:0] * stiff_ff;
         pp_hi_ff    <= pen_ff[37:19] * stiff_ff;
         cmag3_ff    <= cmag2_ff;
         neg3_ff     <= neg2_ff;
         contact3_ff <= contact2_ff;
         stamp3_ff   <= stamp2_ff;
      end
   end

   // -------------------------------------------------------------------------
   // Stage 4: full product, special cases and divider setup.
   // The quotient overflows once P reaches 2^21 times the cosine.
   // -------------------------------------------------------------------------
   logic [61:0]           p_full;
   tlcf_pkg::div_type     div_init;
   tlcf_pkg::div_ctl_type ctl_init;

   always_comb begin
      p_full       = {pp_hi_ff, 19'b0} + 62'(pp_lo_ff);
      ctl_init.contact = contact3_ff;
      ctl_init.neg     = neg3_ff;
      ctl_init.pzero   = (p_full == 62'd0);
      ctl_init.czero   = (cmag3_ff == 32'd0);
      ctl_init.ovf     = (p_full[61:21] >= {9'd0, cmag3_ff});
      div_init.dvs = cmag3_ff;
      div_init.num = {p_full[21:0], 10'b0};
      div_init.quo = '0;
      div_init.rem = (ctl_init.ovf || ctl_init.czero) ? 32'd0 : p_full[53:22];
   end

   logic                  v4_ff;
   tlcf_pkg::div_type     div4_ff;
   tlcf_pkg::div_ctl_type ctl4_ff;
   tlcf_pkg::stamp_type   stamp4_ff;
   logic                  drm_cell [0:DS];

   assign drm[0] = !v4_ff || drm[1];
   assign drm[1] = drm_cell[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff <= 1'b0;
      end else if (drm[0]) begin
         v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (drm[0]) begin
         div4_ff   <= div_init;
         ctl4_ff   <= ctl_init;
         stamp4_ff <= stamp3_ff;
      end
   end

   assign dv[0]  = v4_ff;
   assign dd[0]  = div4_ff;
   assign dc[0]  = ctl4_ff;
   assign dst[0] = stamp4_ff;

   // -------------------------------------------------------------------------
   // Divider chain, one quotient bit per cell.
   // -------------------------------------------------------------------------
   for (genvar k = 0; k < DS; k++) begin : g_div
      tlcf_div_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (dv[k]),
         .in_div    (dd[k]),
         .in_ctl    (dc[k]),
         .in_stamp  (dst[k]),
         .room_in   (drm_cell[k+1]),
         .room_out  (drm_cell[k]),
         .out_valid (dv[k+1]),
         .out_div   (dd[k+1]),
         .out_ctl   (dc[k+1]),
         .out_stamp (dst[k+1])
      );
   end
   assign drm_cell[DS] = room_s5;

   // -------------------------------------------------------------------------
   // Stage 5: normal force magnitude with clamping.
   // -------------------------------------------------------------------------
   tlcf_pkg::div_type     dlast;
   tlcf_pkg::div_ctl_type clast;
   logic [31:0]           mn_in, lim_n;
   logic                  neg5_in, sat5_in;

   assign dlast = dd[DS];
   assign clast = dc[DS];

   always_comb begin
      neg5_in = clast.neg;
      sat5_in = 1'b0;
      lim_n   = clast.neg ? tlcf_pkg::MAG_NEG_MAX : tlcf_pkg::MAG_POS_MAX;
      if (!clast.contact || clast.pzero) begin
         mn_in = '0;
      end else if (clast.czero) begin
         neg5_in = 1'b0;
         mn_in   = tlcf_pkg::MAG_POS_MAX;
         sat5_in = 1'b1;
      end else if (clast.ovf || (dlast.quo > lim_n)) begin
         mn_in   = lim_n;
         sat5_in = 1'b1;
      end else begin
         mn_in = dlast.quo;
      end
   end

   logic                v5_ff;
   logic        [31:0]  mn5_ff;
   logic                neg5_ff, sat5_ff, contact5_ff;
   tlcf_pkg::stamp_type stamp5_ff;

   assign room_s5 = !v5_ff || room_s6;

   always_ff @(posedge clock) begin
      if (reset) begin
         v5_ff <= 1'b0;
      end else if (room_s5) begin
         v5_ff <= dv[DS];
      end
   end

   always_ff @(posedge clock) begin
      if (room_s5) begin
         mn5_ff      <= mn_in;
         neg5_ff     <= neg5_in;
         sat5_ff     <= sat5_in;
         contact5_ff <= clast.contact;
         stamp5_ff   <= dst[DS];
      end
   end

   // -------------------------------------------------------------------------
   // Stage 6: friction product.
   // -------------------------------------------------------------------------
   logic                v6_ff;
   logic        [47:0]  fr6_ff;
   logic        [31:0]  mn6_ff;
   logic                neg6_ff, sat6_ff, contact6_ff;
   tlcf_pkg::stamp_type stamp6_ff;

   assign room_s6 = !v6_ff || room_out;

   always_ff @(posedge clock) begin
      if (reset) begin
         v6_ff <= 1'b0;
      end else if (room_s6) begin
         v6_ff <= v5_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (room_s6) begin
         fr6_ff      <= mn5_ff * mu_ff;
         mn6_ff      <= mn5_ff;
         neg6_ff     <= neg5_ff;
         sat6_ff     <= sat5_ff;
         contact6_ff <= contact5_ff;
         stamp6_ff   <= stamp5_ff;
      end
   end

   // -------------------------------------------------------------------------
   // Output register: friction clamp and signs.
   // -------------------------------------------------------------------------
   logic [33:0] mf, lim_f;
   logic [31:0] mf_c;
   logic        sat_o;

   always_comb begin
      mf    = fr6_ff[47:14];
      lim_f = neg6_ff ? {2'b00, tlcf_pkg::MAG_POS_MAX} : {2'b00, tlcf_pkg::MAG_NEG_MAX};
      sat_o = sat6_ff;
      if (mf > lim_f) begin
         mf_c  = lim_f[31:0];
         sat_o = 1'b1;
      end else begin
         mf_c = mf[31:0];
      end
   end

   logic                rsp_valid_ff;
   logic        [31:0]  sec_ff;
   logic        [29:0]  nsec_ff;
   logic signed [31:0]  fx_ff, fy_ff;
   logic                contact_ff, sat_ff;

   assign room_out = !rsp_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (room_out) begin
         rsp_valid_ff <= v6_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (room_out) begin
         sec_ff     <= stamp6_ff.sec;
         nsec_ff    <= stamp6_ff.nsec;
         fy_ff      <= neg6_ff ? -$signed(mn6_ff) : $signed(mn6_ff);
         fx_ff      <= neg6_ff ? $signed(mf_c) : -$signed(mf_c);
         contact_ff <= contact6_ff;
         sat_ff     <= sat_o;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_out_stamp_sec  = sec_ff;
   assign rsp_out_stamp_nsec = nsec_ff;
   assign rsp_force_x        = fx_ff;
   assign rsp_force_y        = fy_ff;
   assign rsp_in_contact     = contact_ff;
   assign rsp_saturated      = sat_ff;

   // -------------------------------------------------------------------------
   // Assertions.
   // -------------------------------------------------------------------------
   // Without contact there is no force and no clamp.
   a_no_contact_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_in_contact |->
         rsp_force_x == 32'sd0 && rsp_force_y == 32'sd0 && !rsp_saturated)
      else $error("force without contact");

   // A clamp only happens on a contact.
   a_sat_needs_contact: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_saturated |-> rsp_in_contact)
      else $error("saturation without contact");

   // Zero normal force without clamping gives zero friction.
   a_zero_normal_zero_friction: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_saturated && rsp_force_y == 32'sd0 |-> rsp_force_x == 32'sd0)
      else $error("friction without normal force");

   // A free receiver lets the whole chain move, so the request side is open.
   a_open_when_drained: assert property (@(posedge clock) disable iff (reset)
      !rsp_stall |-> !req_stall)
      else $error("request stalled while response side is free");

endmodule
`default_nettype wire

FILE: tb/sv/tb_two_link_contact_force.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tb_two_link_contact_force: self-checking bench of the contact force block
// Drives finger states through the request channel under several register
// settings and idle patterns. Each response is checked field by field against
// set values or a fixed-point model of the kinematics, spring and friction laws.
// ----------------------------------------------------------------------------
module tb_two_link_contact_force;

   localparam int LATENCY     = 56;
   localparam int CYCLE_LIMIT = 400000;
   localparam int PHASE_ITEMS = 280;

   localparam longint ATAN_Q16 [16] = '{51472, 30386, 16055, 8150, 4091, 2047,
      1024, 512, 256, 128, 64, 32, 16, 8, 4, 2};
   localparam longint unsigned POS_LIMIT = 64'd2147483647;
   localparam longint unsigned NEG_LIMIT = 64'd2147483648;

   typedef struct {
      logic        [31:0] sec;
      logic        [29:0] nsec;
      logic signed [15:0] joint;
      logic signed [15:0] base_ang;
      logic signed [23:0] bx;
      logic signed [23:0] by;
   } finger_state_type;

   typedef struct {
      logic        [31:0] sec;
      logic        [29:0] nsec;
      logic signed [31:0] fx;
      logic signed [31:0] fy;
      logic               contact;
      logic               sat;
   } force_result_type;

   typedef struct {
      finger_state_type st;
      logic             contact;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [31:0] req_stamp_sec = '0;
   logic [29:0] req_stamp_nsec = '0;
   logic signed [15:0] req_joint_angle = '0;
   logic signed [15:0] req_base_angle = '0;
   logic signed [23:0] req_base_x = '0;
   logic signed [23:0] req_base_y = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [31:0] rsp_out_stamp_sec;
   logic [29:0] rsp_out_stamp_nsec;
   logic signed [31:0] rsp_force_x;
   logic signed [31:0] rsp_force_y;
   logic rsp_in_contact;
   logic rsp_saturated;
   logic csr_we = 1'b0;
   logic [2:0] csr_index = '0;
   logic [23:0] csr_wdata = '0;

   // Register mirror used by the force model.
   logic        [22:0] prox_len;
   logic        [22:0] dist_len;
   logic signed [23:0] extent;
   logic        [23:0] spring_k;
   logic        [15:0] mu;
   logic        [7:0]  surf_mode;

   force_result_type pending_forces[$];
   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   int fail_count = 0;
   int cycles = 0;

   two_link_contact_force u_dut (.*);

   always #5 clock = ~clock;

   // Rotation CORDIC with wrap into one turn and half-turn folding.
   function automatic void cordic_trig(input longint ang, output longint c,
                                       output longint s);
      longint x, y, z, nx;
      bit flip;
      x = 652032874;
      y = 0;
      z = ang;
      flip = 0;
      while (z > 205887) z -= 411774;
      while (z < -205887) z += 411774;
      if (z > 102944) begin
         z -= 205887;
         flip = 1;
      end else if (z < -102944) begin
         z += 205887;
         flip = 1;
      end
      for (int i = 0; i < 16; i++) begin
         if (z >= 0) begin
            nx = x - (y >>> i);
            y = y + (x >>> i);
            z -= ATAN_Q16[i];
         end else begin
            nx = x + (y >>> i);
            y = y - (x >>> i);
            z += ATAN_Q16[i];
         end
         x = nx;
      end
      c = flip ? -x : x;
      s = flip ? -y : y;
   endfunction

   function automatic longint unsigned clamp_force(input longint unsigned m,
                                                   input bit neg, inout bit sat);
      longint unsigned lim;
      lim = neg ? NEG_LIMIT : POS_LIMIT;
      if (m > lim) begin
         sat = 1;
         return lim;
      end
      return m;
   endfunction

   // Fingertip position, penetration and the resulting normal and friction force.
   function automatic force_result_type predict_forces(input finger_state_type st);
      force_result_type r;
      longint c1, s1, c2, s2, hx, hy, ja, ba, lp, ld;
      longint unsigned pen, p, c, q, rm, mn, mf;
      bit neg, sat;
      ja = st.joint;
      ba = st.base_ang;
      lp = prox_len;
      ld = dist_len;
      sat = 0;
      cordic_trig((ba + ja) * 8, c1, s1);
      cordic_trig(ba * 8, c2, s2);
      hx = longint'(st.bx) * (64'sd1 <<< 30) + lp * s1 + ld * s2;
      hy = longint'(st.by) * (64'sd1 <<< 30) - (lp * c1 + ld * c2);
      r.sec = st.sec;
      r.nsec = st.nsec;
      r.fx = '0;
      r.fy = '0;
      r.contact = 1'b0;
      if (hx <= longint'(extent) * (64'sd1 <<< 30)
          && surf_mode == tlcf_pkg::SURFACE_FLAT && hy <= 0) begin
         pen = longint'(-hy);
         pen = pen >> 18;
         p = pen * spring_k;
         neg = c1 < 0;
         c = neg ? -c1 : c1;
         r.contact = 1'b1;
         if (p == 0) begin
            mn = 0;
         end else if (c == 0) begin
            neg = 0;
            mn = POS_LIMIT;
            sat = 1;
         end else begin
            q = p / c;
            rm = p % c;
            if (q >= (64'd1 << 21)) mn = NEG_LIMIT + 1;
            else mn = (q << 10) + (rm << 10) / c;
            mn = clamp_force(mn, neg, sat);
         end
         mf = (mn * mu) >> 14;
         // Friction opposes the normal force in sign.
         mf = clamp_force(mf, !neg, sat);
         r.fy = neg ? -longint'(mn) : longint'(mn);
         r.fx = neg ? longint'(mf) : -longint'(mf);
      end
      r.sat = sat;
      return r;
   endfunction

   // One register write; the caller drops the write enable afterwards.
   task automatic write_reg(input tlcf_pkg::csr_index_type idx, input logic [23:0] val);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      case (idx)
         tlcf_pkg::CSR_PROXIMAL_LENGTH: prox_len = val[22:0];
         tlcf_pkg::CSR_DISTAL_LENGTH:   dist_len = val[22:0];
         tlcf_pkg::CSR_SURFACE_EXTENT:  extent = val;
         tlcf_pkg::CSR_STIFFNESS:       spring_k = val;
         tlcf_pkg::CSR_FRICTION_COEFF:  mu = val[15:0];
         tlcf_pkg::CSR_SURFACE_MODE:    surf_mode = val[7:0];
         default: ;
      endcase
   endtask

   task automatic set_regs(input logic [23:0] lp, ld, ext, k, m, mode);
      write_reg(tlcf_pkg::CSR_PROXIMAL_LENGTH, lp);
      write_reg(tlcf_pkg::CSR_DISTAL_LENGTH, ld);
      write_reg(tlcf_pkg::CSR_SURFACE_EXTENT, ext);
      write_reg(tlcf_pkg::CSR_STIFFNESS, k);
      write_reg(tlcf_pkg::CSR_FRICTION_COEFF, m);
      write_reg(tlcf_pkg::CSR_SURFACE_MODE, mode);
      csr_we <= 1'b0;
   endtask

   // Send one transaction; the expectation is queued once it is accepted.
   task automatic send_state(input finger_state_type st, input bit use_typed,
                             input force_result_type typed);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_stamp_sec <= st.sec;
      req_stamp_nsec <= st.nsec;
      req_joint_angle <= st.joint;
      req_base_angle <= st.base_ang;
      req_base_x <= st.bx;
      req_base_y <= st.by;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      pending_forces.push_back(use_typed ? typed : predict_forces(st));
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (pending_forces.size() != 0) @(posedge clock);
      repeat (LATENCY + 4) @(posedge clock);
   endtask

   // Random finger state: mostly near the surface, the rest raw bits.
   function automatic finger_state_type random_state();
      finger_state_type st;
      st.sec = $urandom;
      st.nsec = 30'($urandom);
      st.joint = 16'($urandom);
      st.base_ang = 16'($urandom);
      st.bx = 24'($urandom);
      st.by = 24'($urandom);
      if ($urandom_range(9) < 7) begin
         st.bx = $signed(24'($urandom_range(32768))) - 24'sd16384;
         st.by = $signed(24'($urandom_range(32768))) - 24'sd8192;
         st.joint = $signed(16'($urandom_range(25736))) - 16'sd12868;
         st.base_ang = $signed(16'($urandom_range(25736))) - 16'sd12868;
         // Proximal link near a right angle, where the cosine nearly vanishes.
         if ($urandom_range(7) == 0)
            st.joint = ($urandom_range(1) ? 16'sd12868 : -16'sd12868) - st.base_ang
                       + $signed(16'($urandom_range(8))) - 16'sd4;
      end
      return st;
   endfunction

   task automatic check_field(input string name, input longint e, input longint a);
      if (e != a) begin
         $error("%s: expected %0d, got %0d", name, e, a);
         fail_count++;
      end
   endtask

   // Response checker.
   always @(posedge clock) begin
      force_result_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_forces.size() == 0) begin
            $error("response with no transaction outstanding");
            fail_count++;
         end else begin
            e = pending_forces.pop_front();
            check_field("out_stamp_sec", e.sec, rsp_out_stamp_sec);
            check_field("out_stamp_nsec", e.nsec, rsp_out_stamp_nsec);
            check_field("force_x", e.fx, rsp_force_x);
            check_field("force_y", e.fy, rsp_force_y);
            check_field("in_contact", e.contact, rsp_in_contact);
            check_field("saturated", e.sat, rsp_saturated);
         end
      end
   end

   // Receiver back-pressure.
   always @(posedge clock) begin
      rsp_stall <= !reset && ($urandom_range(99) < recv_stall_pct);
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("two_link_contact_force: mismatch");
         $finish;
      end
   end

   initial begin
      stim_row_type rows[12];
      force_result_type typed;
      finger_state_type st;
      prox_len = '0;
      dist_len = '0;
      extent = '0;
      spring_k = '0;
      mu = '0;
      surf_mode = tlcf_pkg::SURFACE_FLAT;
      // With zero lengths the tip sits at the base; zero stiffness gives no force.
      rows[0]  = '{'{32'd0, 30'd0, 16'sd0, 16'sd0, 24'sd0, 24'sd0}, 1'b1};
      rows[1]  = '{'{32'hFFFFFFFF, 30'h3FFFFFFF, 16'sd0, 16'sd0, 24'sd1, 24'sd0}, 1'b0};
      rows[2]  = '{'{32'd7, 30'd999999999, 16'sd0, 16'sd0, 24'sd0, 24'sd1}, 1'b0};
      rows[3]  = '{'{32'd1, 30'd1, 16'sh7FFF, 16'sh7FFF, -24'sd8388608,
                     -24'sd8388608}, 1'b1};
      rows[4]  = '{'{32'd2, 30'd2, -16'sd32768, -16'sd32768, 24'sd8388607,
                     -24'sd1}, 1'b0};
      rows[5]  = '{'{32'd3, 30'd3, 16'sh7FFF, -16'sd32768, -24'sd1,
                     24'sd8388607}, 1'b0};
      rows[6]  = '{'{32'h80000000, 30'h20000000, 16'sd12868, 16'sd0, -24'sd4096,
                     -24'sd4096}, 1'b1};
      rows[7]  = '{'{32'h5A5A5A5A, 30'h15555555, -16'sd12868, 16'sd25736, 24'sd0,
                     -24'sd100}, 1'b1};
      rows[8]  = '{'{32'hA5A5A5A5, 30'h2AAAAAAA, 16'sd0, 16'sd12868, -24'sd5,
                     -24'sd40000}, 1'b1};
      rows[9]  = '{'{32'd9, 30'd9, 16'sd25736, -16'sd25736, 24'sd2048, 24'sd0}, 1'b0};
      rows[10] = '{'{32'd10, 30'd10, 16'sd100, 16'sd100, -24'sd2048, -24'sd8000}, 1'b1};
      rows[11] = '{'{32'd11, 30'd11, -16'sd3000, 16'sd6000, -24'sd8000, 24'sd2000},
                   1'b0};
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset settings: outcomes follow from the base position alone.
      foreach (rows[i]) begin
         typed = '{rows[i].st.sec, rows[i].st.nsec, 32'sd0, 32'sd0, rows[i].contact, 1'b0};
         send_state(rows[i].st, 1'b1, typed);
      end
      drain();

      // Real link lengths and a stiff surface: same rows through the force model.
      set_regs(24'd4096, 24'd4096, 24'd0, 24'd65536, 24'd8192, 24'd1);
      foreach (rows[i]) send_state(rows[i].st, 1'b0, typed);
      drain();

      // Random phases, each with its own register setting and one of three idle patterns.
      for (int ph = 0; ph < 6; ph++) begin
         case (ph)
            0: set_regs(24'd4096, 24'd2048, 24'd8192, 24'd40000, 24'd16384, 24'd1);
            1: set_regs(24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 24'hFFFFFF, 24'hFFFF, 24'd1);
            2: set_regs(24'd8192, 24'd4096, 24'h800000, 24'd4096, 24'd0, 24'd1);
            3: set_regs(24'd0, 24'd6000, 24'd0, 24'd1, 24'd1, 24'd255);
            4: set_regs(24'd3000, 24'd5000, 24'd20000, 24'h7FFFFF, 24'h8000, 24'd0);
            default: set_regs(24'd5000, 24'd5000, 24'd12000, 24'd200000, 24'd12000,
                              24'd1);
         endcase
         send_idle_pct = (ph < 2) ? 38 : (ph < 4) ? 83 : 0;
         recv_stall_pct = (ph < 2) ? 83 : (ph < 4) ? 38 : 0;
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            st = random_state();
            send_state(st, 1'b0, typed);
            // Hold off mid-phase until the pipeline has emptied.
            if (ph == 5 && n == PHASE_ITEMS / 2) begin
               req_valid <= 1'b0;
               while (pending_forces.size() != 0) @(posedge clock);
            end
         end
         drain();
      end

      if (fail_count == 0) begin
         $display("two_link_contact_force: match");
      end else begin
         $display("two_link_contact_force: mismatch");
      end
      $finish;
   end

endmodule
`default_nettype wire
